// ===== rtl/core/ipc_pkg.sv =====
// Shared types and constants for the isolated pixel counter.
// Pixel flag encoding, count width, register indexes and the struct bundles
// passed between the top level and the neighbor update logic.
package ipc_pkg;

	localparam int COUNT_W    = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [COUNT_W-1:0]    COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;

	// bit 0: pixel set, bit 1: still counted as isolated
	typedef logic [1:0] flag_t;

	localparam flag_t FLAG_NONE = 2'b00;
	localparam flag_t FLAG_SET  = 2'b01;
	localparam flag_t FLAG_CAND = 2'b11;
	localparam int    SET_B     = 0;

	// where the upper-right neighbor comes from on the next pixel
	typedef enum logic [1:0] {
		UR_NONE = 2'b00,
		UR_EVEN = 2'b01,
		UR_ODD  = 2'b10
	} ur_src_t;

	// masked neighbors of the current pixel
	typedef struct packed {
		flag_t ul;
		flag_t uc;
		flag_t ur;
		flag_t lf;
	} win_t;

	// neighbor flags after update, flags of the current pixel, new count
	typedef struct packed {
		flag_t               uc;
		flag_t               ur;
		flag_t               lf;
		flag_t               cur;
		logic                touched;
		logic [COUNT_W-1:0]  count;
	} nbr_res_t;

endpackage

// ===== rtl/core/ipc_line_bank.sv =====
// One bank of the line store: one write port, one read port, registered read.
// A read of the address written in the same cycle returns the new data.
// Uses ipc_pkg for the flag type.
module ipc_line_bank #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  ipc_pkg::flag_t wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output ipc_pkg::flag_t rdata
);

	ipc_pkg::flag_t line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			line_q[waddr] <= wdata;
		end
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= line_q[raddr];
			end
		end
	end

endmodule

// ===== rtl/core/ipc_nbr_update.sv =====
// Neighbor rule for one pixel: new candidate or withdrawal of touched candidates,
// with the saturating running count. Purely combinational.
// Uses ipc_pkg for flags, window and result structs.
module ipc_nbr_update (
	input  logic                         pix,
	input  ipc_pkg::win_t                win,
	input  logic [ipc_pkg::COUNT_W-1:0]  count,
	output ipc_pkg::nbr_res_t            res
);

	logic       any_set;
	logic [2:0] n_cand;

	function automatic ipc_pkg::flag_t touch(input ipc_pkg::flag_t n);
		return (n == ipc_pkg::FLAG_CAND) ? ipc_pkg::FLAG_SET : n;
	endfunction

	assign any_set = win.ul[ipc_pkg::SET_B] | win.uc[ipc_pkg::SET_B] |
	                 win.ur[ipc_pkg::SET_B] | win.lf[ipc_pkg::SET_B];

	assign n_cand = 3'(win.ul == ipc_pkg::FLAG_CAND) + 3'(win.uc == ipc_pkg::FLAG_CAND) +
	                3'(win.ur == ipc_pkg::FLAG_CAND) + 3'(win.lf == ipc_pkg::FLAG_CAND);

	always_comb begin
		res.uc      = win.uc;
		res.ur      = win.ur;
		res.lf      = win.lf;
		res.cur     = ipc_pkg::FLAG_NONE;
		res.touched = 1'b0;
		res.count   = count;
		if (pix) begin
			if (any_set) begin
				// joins earlier set pixels: any neighbor candidates drop out
				res.uc      = touch(win.uc);
				res.ur      = touch(win.ur);
				res.lf      = touch(win.lf);
				res.cur     = ipc_pkg::FLAG_SET;
				res.touched = 1'b1;
				res.count   = (count >= ipc_pkg::COUNT_W'(n_cand)) ?
				              count - ipc_pkg::COUNT_W'(n_cand) : '0;
			end else begin
				res.cur   = ipc_pkg::FLAG_CAND;
				res.count = (count == ipc_pkg::COUNT_MAX) ? count : count + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/isolated_pixel_counter.sv =====
// Top level of the isolated pixel counter: handshakes, position and window state,
// line store in two banks (even and odd columns), result register.
// Depends on ipc_pkg, ipc_line_bank and ipc_nbr_update.
//
//  channel  signals                         direction  payload
//  -------  ------------------------------  ---------  ---------------------------
//  pixel    in_valid / in_ready             in         pixel_is_star
//  result   out_valid / out_ready           out        isolated_count (one per frame)
//  config   cfg_valid / cfg_ready           in         cfg_index, cfg_data
//
// One pixel per cycle sustained; the loop that sets this is the update of the neighbor
// window, the count and the registered line store read ahead at c+2. A pixel is
// worked from the input register after its transfer; the frame count is then
// offered from the result register. The pixel path stalls only when a frame's
// last pixel finds the result register still full. Reset clears all control
// state; the line store has no clearing pass and needs none. Config transfers
// wait while a pixel is in flight or offered on the pixel channel.
module isolated_pixel_counter #(
	parameter int unsigned MAX_COLS = 1024,
	parameter int unsigned MAX_ROWS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pixel_is_star,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ipc_pkg::COUNT_W-1:0]     isolated_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ipc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CIW    = $clog2(MAX_COLS);
	localparam int RIW    = $clog2(MAX_ROWS);
	localparam int CNW    = $clog2(MAX_COLS + 1);
	localparam int RNW    = $clog2(MAX_ROWS + 1);
	localparam int CXW    = CNW + 1;
	localparam int BDEPTH = (MAX_COLS + 1) / 2;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

	// configuration
	logic [ipc_pkg::CFG_DATA_W-1:0] frame_rows_q, frame_cols_q;
	logic [CNW-1:0]                 cols;
	logic [RNW-1:0]                 rows;

	// input stage and result register
	logic                           valid_s1, pix_s1;
	logic                           out_valid_q;
	logic [ipc_pkg::COUNT_W-1:0]    out_count_q;

	// position, window and count
	logic [CIW-1:0]                 col_q;
	logic [RIW-1:0]                 row_q;
	ipc_pkg::flag_t                 lf_q, ul_q, uc_q;
	logic                           uc_mem_q;
	ipc_pkg::ur_src_t               ur_sel_q;
	logic [ipc_pkg::COUNT_W-1:0]    count_q;

	logic [CIW-1:0]                 c, cm1;
	logic [RIW-1:0]                 r;
	logic [CIW:0]                   c2;
	logic                           first_row, first_col, last_col, last_row;
	logic                           frame_end, row_end, nxt_ok, cols_gt1;
	logic                           step_go, w1_en;
	ipc_pkg::flag_t                 uc_eff, ur_eff, rd_even, rd_odd;
	ipc_pkg::win_t                  win;
	ipc_pkg::nbr_res_t              res;
	logic [BAW-1:0]                 a_c, a_cm1, a_c2;

	logic                           we_e, we_o, re_e, re_o;
	logic [BAW-1:0]                 waddr_e, waddr_o, raddr_e, raddr_o;
	ipc_pkg::flag_t                 wdata_e, wdata_o;

	// effective frame size: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (frame_cols_q == '0) begin
			cols = CNW'(1);
		end else if (32'(frame_cols_q) > MAX_COLS) begin
			cols = CNW'(MAX_COLS);
		end else begin
			cols = CNW'(frame_cols_q);
		end
		if (frame_rows_q == '0) begin
			rows = RNW'(1);
		end else if (32'(frame_rows_q) > MAX_ROWS) begin
			rows = RNW'(MAX_ROWS);
		end else begin
			rows = RNW'(frame_rows_q);
		end
	end

	// a position past a shrunk size counts as the last one
	assign c   = (CNW'(col_q) >= cols) ? CIW'(cols - 1'b1) : col_q;
	assign r   = (RNW'(row_q) >= rows) ? RIW'(rows - 1'b1) : row_q;
	assign cm1 = c - CIW'(1);
	assign c2  = (CIW + 1)'(c) + (CIW + 1)'(2);

	assign first_row = (r == '0);
	assign first_col = (c == '0);
	assign last_col  = ((CNW'(c) + CNW'(1)) == cols);
	assign last_row  = ((RNW'(r) + RNW'(1)) == rows);
	assign frame_end = last_col && last_row;
	assign row_end   = last_col && !last_row;
	assign cols_gt1  = (cols != CNW'(1));
	assign nxt_ok    = !first_row && ((CXW'(c) + CXW'(2)) < CXW'(cols));

	always_comb begin
		uc_eff = uc_mem_q ? rd_even : uc_q;
		case (ur_sel_q)
			ipc_pkg::UR_EVEN: ur_eff = rd_even;
			ipc_pkg::UR_ODD:  ur_eff = rd_odd;
			default:          ur_eff = ipc_pkg::FLAG_NONE;
		endcase
	end

	always_comb begin
		win.ul = (first_row || first_col) ? ipc_pkg::FLAG_NONE : ul_q;
		win.uc = first_row ? ipc_pkg::FLAG_NONE : uc_eff;
		win.ur = (first_row || last_col) ? ipc_pkg::FLAG_NONE : ur_eff;
		win.lf = first_col ? ipc_pkg::FLAG_NONE : lf_q;
	end

	ipc_nbr_update u_nbr (
		.pix   (pix_s1),
		.win   (win),
		.count (count_q),
		.res   (res)
	);

	// handshakes; a pixel on offer goes ahead of a config write
	assign step_go   = valid_s1 && !(frame_end && out_valid_q && !out_ready);
	assign in_ready  = !valid_s1 || step_go;
	assign cfg_ready = !valid_s1 && !in_valid;
	assign out_valid = out_valid_q;
	assign isolated_count = out_count_q;

	// line store: the current pixel goes to column c, an updated left pixel to c-1;
	// the two always fall in different banks
	assign a_c   = BAW'(c >> 1);
	assign a_cm1 = BAW'(cm1 >> 1);
	assign a_c2  = BAW'(c2 >> 1);
	assign w1_en = res.touched && !first_col;

	always_comb begin
		we_e    = step_go && (c[0] ? w1_en : 1'b1);
		waddr_e = c[0] ? a_cm1 : a_c;
		wdata_e = c[0] ? res.lf : res.cur;
		we_o    = step_go && (c[0] ? 1'b1 : w1_en);
		waddr_o = c[0] ? a_c : a_cm1;
		wdata_o = c[0] ? res.cur : res.lf;
		// row end fetches columns 0 and 1; mid row fetches column c+2
		re_e    = step_go && (row_end || (!last_col && nxt_ok && !c[0]));
		re_o    = step_go && ((row_end && cols_gt1) || (!last_col && nxt_ok && c[0]));
		raddr_e = row_end ? '0 : a_c2;
		raddr_o = row_end ? '0 : a_c2;
	end

	ipc_line_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank_even (
		.clk   (clk),
		.we    (we_e),
		.waddr (waddr_e),
		.wdata (wdata_e),
		.re    (re_e),
		.raddr (raddr_e),
		.rdata (rd_even)
	);

	ipc_line_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank_odd (
		.clk   (clk),
		.we    (we_o),
		.waddr (waddr_o),
		.wdata (wdata_o),
		.re    (re_o),
		.raddr (raddr_o),
		.rdata (rd_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= ipc_pkg::SIZE_RESET;
			frame_cols_q <= ipc_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ipc_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				ipc_pkg::CFG_FRAME_COLS: frame_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s1 <= pixel_is_star;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && frame_end) begin
			out_count_q <= res.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			lf_q     <= ipc_pkg::FLAG_NONE;
			ul_q     <= ipc_pkg::FLAG_NONE;
			uc_q     <= ipc_pkg::FLAG_NONE;
			uc_mem_q <= 1'b0;
			ur_sel_q <= ipc_pkg::UR_NONE;
			count_q  <= '0;
		end else if (step_go) begin
			if (frame_end) begin
				col_q    <= '0;
				row_q    <= '0;
				lf_q     <= ipc_pkg::FLAG_NONE;
				ul_q     <= ipc_pkg::FLAG_NONE;
				uc_q     <= ipc_pkg::FLAG_NONE;
				uc_mem_q <= 1'b0;
				ur_sel_q <= ipc_pkg::UR_NONE;
				count_q  <= '0;
			end else if (row_end) begin
				col_q    <= '0;
				row_q    <= r + RIW'(1);
				lf_q     <= ipc_pkg::FLAG_NONE;
				ul_q     <= ipc_pkg::FLAG_NONE;
				uc_q     <= ipc_pkg::FLAG_NONE;
				uc_mem_q <= 1'b1;
				ur_sel_q <= cols_gt1 ? ipc_pkg::UR_ODD : ipc_pkg::UR_NONE;
				count_q  <= res.count;
			end else begin
				col_q    <= c + CIW'(1);
				row_q    <= r;
				lf_q     <= res.cur;
				ul_q     <= res.uc;
				uc_q     <= res.ur;
				uc_mem_q <= 1'b0;
				if (nxt_ok) begin
					ur_sel_q <= c[0] ? ipc_pkg::UR_ODD : ipc_pkg::UR_EVEN;
				end else begin
					ur_sel_q <= ipc_pkg::UR_NONE;
				end
				count_q  <= res.count;
			end
		end
	end

	// count restarts after every frame
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && frame_end |=> count_q == '0)
		else $error("running count not cleared after frame end");

	// the row-start fetch of column 0 is only consumed at column 0
	a_uc_mem_col0: assert property (@(posedge clk) disable iff (!arst_n)
		uc_mem_q |-> col_q == '0)
		else $error("line store head used away from column 0");

	// the top row never sees data from the line store
	a_row0_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		row_q == '0 |-> (ur_sel_q == ipc_pkg::UR_NONE) && !uc_mem_q)
		else $error("line store fetch pending on the first row");

	// background pixels leave the count alone
	a_bg_count: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && !pix_s1 && !frame_end |=> count_q == $past(count_q))
		else $error("count changed on a background pixel");

endmodule
